@@ rtl/dcsl_pkg.sv @@
`default_nettype none

package dcsl_pkg;

    localparam int CHANNELS  = 4;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHAN_W    = 4;
    localparam int CODE_W    = 16;
    localparam int TIME_W    = 32;
    localparam int FUNC_W    = 2;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK     = 2'd0,
        FN_SET      = 2'd1,
        FN_READBACK = 2'd2,
        FN_UNUSED   = 2'd3
    } func_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;

    localparam logic [CODE_W-1:0] CODE_MID     = 16'h8000;
    localparam logic [CODE_W-1:0] MAX_STEP_RST = 16'd328;
    localparam logic [CODE_W-1:0] INTERVAL_RST = 16'd100;

    typedef struct packed {
        logic [CODE_W-1:0] target;
        logic [CODE_W-1:0] confirmed;
        logic              conf;
        logic              ramp;
        logic [TIME_W-1:0] stamp;
    } chan_rec_t;

    localparam chan_rec_t REC_RESET = '{
        target:    CODE_MID,
        confirmed: '0,
        conf:      1'b0,
        ramp:      1'b0,
        stamp:     '0
    };

    typedef struct packed {
        logic              emit;
        logic [CODE_W-1:0] code;
    } step_res_t;

endpackage

`default_nettype wire

@@ rtl/dcsl_ram.sv @@
`default_nettype none

module dcsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/dcsl_step.sv @@
`default_nettype none

module dcsl_step (
    input  wire dcsl_pkg::func_t                 op,
    input  wire dcsl_pkg::chan_rec_t             rec,
    input  wire logic [dcsl_pkg::CODE_W-1:0]     code,
    input  wire logic [dcsl_pkg::TIME_W-1:0]     now,
    input  wire logic                            broken,
    input  wire logic [dcsl_pkg::CODE_W-1:0]     max_step,
    input  wire logic [dcsl_pkg::CODE_W-1:0]     interval,
    output dcsl_pkg::chan_rec_t                  rec_next,
    output dcsl_pkg::step_res_t                  res
);

    import dcsl_pkg::*;

    logic              up;
    logic [CODE_W-1:0] diff;
    logic [CODE_W-1:0] stepped;
    logic [TIME_W-1:0] elapsed;
    logic              due;

    assign up      = rec.target > rec.confirmed;
    assign diff    = up ? (rec.target - rec.confirmed) : (rec.confirmed - rec.target);
    assign stepped = (diff > max_step)
                   ? (up ? (rec.confirmed + max_step) : (rec.confirmed - max_step))
                   : rec.target;
    assign elapsed = now - rec.stamp;
    assign due     = (elapsed > {{(TIME_W-CODE_W){1'b0}}, interval}) && rec.conf;

    always_comb
    begin
        rec_next = rec;
        res      = '0;
        case (op)
            FN_SET:
            begin
                rec_next.target = code;
                rec_next.ramp   = 1'b1;
            end
            FN_READBACK:
            begin
                rec_next.confirmed = code;
                rec_next.conf      = 1'b1;
            end
            FN_TICK:
            begin
                if (!rec.ramp || broken)
                begin
                    rec_next.stamp = now;
                end
                else if (due)
                begin
                    if (rec.confirmed == rec.target)
                    begin
                        rec_next.ramp = 1'b0;
                    end
                    else
                    begin
                        res.emit       = 1'b1;
                        res.code       = stepped;
                        rec_next.conf  = 1'b0;
                        rec_next.stamp = now;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/dac_code_slew_limiter.sv @@
// channel  | direction | handshake          | payload
// in       | input     | in_valid/in_stall   | func, chan, code_value, now_ms, link_broken
// out      | output    | out_valid/out_stall | write_chan, write_code, last_of_run
// cfg      | input     | cfg_we              | cfg_index, cfg_data
//
// Set-target and readback: read, then write-back of the channel record.
// Tick: one channel record read and written per cycle, except while the output register
// is full and stalled.
// Reset clears the per-channel valid bits; an entry never written reads as its reset value.
// One held write waits in a pending register so that the last of a run can be marked.

`default_nettype none

module dac_code_slew_limiter (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [dcsl_pkg::FUNC_W-1:0]      func,
    input  wire logic [dcsl_pkg::CHAN_W-1:0]      chan,
    input  wire logic [dcsl_pkg::CODE_W-1:0]      code_value,
    input  wire logic [dcsl_pkg::TIME_W-1:0]      now_ms,
    input  wire logic                             link_broken,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [dcsl_pkg::CHAN_W-1:0]      write_chan,
    output logic      [dcsl_pkg::CODE_W-1:0]      write_code,
    output logic                                  last_of_run,
    input  wire logic                             cfg_we,
    input  wire logic [dcsl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dcsl_pkg::CODE_W-1:0]      cfg_data
);

    import dcsl_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RMW   = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CODE_W-1:0] max_step_reg;
    logic [CODE_W-1:0] interval_reg;

    func_t             func_reg, func_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic              broken_reg, broken_next;
    logic [CH_W-1:0]   addr_reg, addr_next;

    logic [CHANNELS-1:0] vld_reg, vld_next;

    logic              out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0] out_chan_reg, out_chan_next;
    logic [CODE_W-1:0] out_code_reg, out_code_next;
    logic              out_last_reg, out_last_next;

    logic              pend_valid_reg, pend_valid_next;
    logic [CHAN_W-1:0] pend_chan_reg, pend_chan_next;
    logic [CODE_W-1:0] pend_code_reg, pend_code_next;

    logic            ram_we;
    logic            ram_re;
    logic [CH_W-1:0] ram_raddr;
    chan_rec_t       ram_rdata;
    chan_rec_t       rec_rd;
    chan_rec_t       rec_wr;
    step_res_t       res;
    logic            out_free;
    logic            proceed;
    logic            chan_ok;

    dcsl_ram #(
        .WIDTH ($bits(chan_rec_t)),
        .DEPTH (CHANNELS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (rec_wr),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rec_rd = vld_reg[addr_reg] ? ram_rdata : REC_RESET;

    dcsl_step u_step (
        .op       (func_reg),
        .rec      (rec_rd),
        .code     (code_reg),
        .now      (now_reg),
        .broken   (broken_reg),
        .max_step (max_step_reg),
        .interval (interval_reg),
        .rec_next (rec_wr),
        .res      (res)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign write_chan  = out_chan_reg;
    assign write_code  = out_code_reg;
    assign last_of_run = out_last_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign proceed  = !(res.emit && pend_valid_reg && !out_free);
    assign chan_ok  = ({1'b0, chan} < (CHAN_W+1)'(CHANNELS));

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        code_next       = code_reg;
        now_next        = now_reg;
        broken_next     = broken_reg;
        addr_next       = addr_reg;
        vld_next        = vld_reg;
        out_valid_next  = out_valid_reg;
        out_chan_next   = out_chan_reg;
        out_code_next   = out_code_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_chan_next  = pend_chan_reg;
        pend_code_next  = pend_code_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = addr_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next   = func_t'(func);
                    code_next   = code_value;
                    now_next    = now_ms;
                    broken_next = link_broken;
                    case (func_t'(func))
                        FN_TICK:
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            addr_next  = '0;
                            state_next = ST_SCAN;
                        end
                        FN_SET, FN_READBACK:
                        begin
                            if (chan_ok)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = chan[CH_W-1:0];
                                addr_next  = chan[CH_W-1:0];
                                state_next = ST_RMW;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RMW:
            begin
                ram_we             = 1'b1;
                vld_next[addr_reg] = 1'b1;
                state_next         = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (proceed)
                begin
                    ram_we             = 1'b1;
                    vld_next[addr_reg] = 1'b1;
                    if (res.emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_chan_next  = pend_chan_reg;
                            out_code_next  = pend_code_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_chan_next  = CHAN_W'(addr_reg);
                        pend_code_next  = res.code;
                    end
                    if (addr_reg == CH_W'(CHANNELS - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = addr_reg + CH_W'(1);
                        addr_next = addr_reg + CH_W'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_chan_next   = pend_chan_reg;
                    out_code_next   = pend_code_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            vld_reg        <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            max_step_reg   <= MAX_STEP_RST;
            interval_reg   <= INTERVAL_RST;
        end
        else
        begin
            state_reg      <= state_next;
            vld_reg        <= vld_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_we && (cfg_index == CFG_MAX_STEP))
            begin
                max_step_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_INTERVAL))
            begin
                interval_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        code_reg      <= code_next;
        now_reg       <= now_next;
        broken_reg    <= broken_next;
        addr_reg      <= addr_next;
        out_chan_reg  <= out_chan_next;
        out_code_reg  <= out_code_next;
        out_last_reg  <= out_last_next;
        pend_chan_reg <= pend_chan_next;
        pend_code_reg <= pend_code_next;
    end

    // a held write never outlives its tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending write left over after tick");

    // scan writes back one record while prefetching the next
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_raddr != addr_reg))
        else $error("record read and written at the same address");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FLUSH) && !pend_valid_reg) |=> (state_reg == ST_IDLE))
        else $error("flush did not return to idle");

    // last write of a run leaves with the flush, never mid-scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_next && !out_valid_reg && out_last_next) |-> (state_reg == ST_FLUSH))
        else $error("end-of-run transfer raised outside flush");

endmodule

`default_nettype wire
